/* hdl/tfn_pkg.sv */
// Shared constants, types and helpers for the triangle face normal pipeline.
// No dependencies; used by triangle_face_normal.
package tfn_pkg;

    localparam int COORD_W  = 32;     // width of one coordinate port
    localparam int SCALE_W  = 30;     // edge and cross components are cut to this many bits
    localparam int NORM_W   = 16;     // width of one normal component
    localparam int BITS_W   = 64;     // span of the leading-one search
    localparam int LEN_W    = 7;      // width of a bit length over BITS_W
    localparam int SHIFT_W  = 6;      // width of a right-shift amount
    localparam int SAT_MAG  = 32768;  // magnitude clamp before sign
    localparam int SAT_POS  = 32767;  // positive clamp after sign

    typedef logic [SHIFT_W-1:0] shift_t;

    // Magnitude of a two's complement coordinate; the most negative value maps to 2^31.
    function automatic logic [COORD_W-1:0] abs_coord(input logic [COORD_W-1:0] x);
        logic [COORD_W-1:0] r;
        r = x[COORD_W-1] ? (~x + 1'b1) : x;
        return r;
    endfunction

    // Least right shift that brings v below 2^SCALE_W.
    function automatic shift_t over_shift(input logic [BITS_W-1:0] v);
        logic [LEN_W-1:0] len;
        shift_t           s;
        len = '0;
        for (int i = 0; i < BITS_W; i++)
        begin
            if (v[i])
            begin
                len = LEN_W'(i + 1);
            end
        end
        if (len > LEN_W'(SCALE_W))
        begin
            s = SHIFT_W'(len - LEN_W'(SCALE_W));
        end
        else
        begin
            s = '0;
        end
        return s;
    endfunction

endpackage

/* hdl/tfn_div.sv */
// Pipelined restoring divider: one quotient bit per register stage, with a sideband.
// No dependencies; instanced by triangle_face_normal.
module tfn_div #(
    parameter int NUM_W  = 48,
    parameter int DEN_W  = 32,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [NUM_W-1:0]  out_quot,
    output logic [SIDE_W-1:0] out_side
);

    logic              valid_reg [NUM_W];
    logic [NUM_W-1:0]  nq_reg    [NUM_W];
    logic [DEN_W-1:0]  rem_reg   [NUM_W];
    logic [DEN_W-1:0]  den_reg   [NUM_W];
    logic [SIDE_W-1:0] side_reg  [NUM_W];

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_stage
        logic              v_in;
        logic [NUM_W-1:0]  nq_in;
        logic [DEN_W-1:0]  rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [SIDE_W-1:0] side_in;
        logic [DEN_W:0]    trial;
        logic [DEN_W:0]    diff;
        logic              fits;
        logic [DEN_W-1:0]  rem_next;
        logic [NUM_W-1:0]  nq_next;

        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign nq_in   = in_num;
            assign rem_in  = '0;
            assign den_in  = in_den;
            assign side_in = in_side;
        end
        else
        begin : g_later
            assign v_in    = valid_reg[k-1];
            assign nq_in   = nq_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // Bring down the next numerator bit; the quotient bit shifts in at the bottom.
        always_comb
        begin
            trial    = {rem_in, nq_in[NUM_W-1]};
            diff     = trial - {1'b0, den_in};
            fits     = (trial >= {1'b0, den_in});
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            nq_next  = {nq_in[NUM_W-2:0], fits};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            nq_reg[k]   <= nq_next;
            rem_reg[k]  <= rem_next;
            den_reg[k]  <= den_in;
            side_reg[k] <= side_in;
        end
    end

    assign out_valid = valid_reg[NUM_W-1];
    assign out_quot  = nq_reg[NUM_W-1];
    assign out_side  = side_reg[NUM_W-1];

endmodule

/* hdl/tfn_sqrt.sv */
// Pipelined integer square root: one root bit per register stage, with a sideband.
// No dependencies; instanced by triangle_face_normal.
module tfn_sqrt #(
    parameter int IN_W   = 62,
    parameter int SIDE_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [IN_W-1:0]     in_rad,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output logic [IN_W/2-1:0]   out_root,
    output logic [SIDE_W-1:0]   out_side
);

    localparam int OUT_W = IN_W / 2;
    localparam int REM_W = OUT_W + 2;

    logic              valid_reg [OUT_W];
    logic [IN_W-1:0]   rad_reg   [OUT_W];
    logic [REM_W-1:0]  rem_reg   [OUT_W];
    logic [OUT_W-1:0]  root_reg  [OUT_W];
    logic [SIDE_W-1:0] side_reg  [OUT_W];

    for (genvar k = 0; k < OUT_W; k++)
    begin : g_stage
        logic              v_in;
        logic [IN_W-1:0]   rad_in;
        logic [REM_W-1:0]  rem_in;
        logic [OUT_W-1:0]  root_in;
        logic [SIDE_W-1:0] side_in;
        logic [REM_W+1:0]  cur;
        logic [REM_W+1:0]  trial;
        logic [REM_W+1:0]  diff;
        logic              fits;
        logic [REM_W-1:0]  rem_next;
        logic [OUT_W-1:0]  root_next;

        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rad_in  = in_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = in_side;
        end
        else
        begin : g_later
            assign v_in    = valid_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // Take two radicand bits; try 4r + 1 against the remainder.
        always_comb
        begin
            cur       = {rem_in, rad_in[IN_W-1:IN_W-2]};
            trial     = {2'b00, root_in, 2'b01};
            diff      = cur - trial;
            fits      = (cur >= trial);
            rem_next  = fits ? diff[REM_W-1:0] : cur[REM_W-1:0];
            root_next = {root_in[OUT_W-2:0], fits};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rad_reg[k]  <= {rad_in[IN_W-3:0], 2'b00};
            rem_reg[k]  <= rem_next;
            root_reg[k] <= root_next;
            side_reg[k] <= side_in;
        end
    end

    assign out_valid = valid_reg[OUT_W-1];
    assign out_root  = root_reg[OUT_W-1];
    assign out_side  = side_reg[OUT_W-1];

endmodule

/* hdl/triangle_face_normal.sv */
// Throughput: one triangle per cycle; busy is always low and results cannot be held off.
// The latency is set by the bit-per-stage dividers (perspective and normalise) and the root.
// Reset clears every valid bit at once; items in flight are dropped.
// Depends on tfn_pkg, tfn_div and tfn_sqrt.
module triangle_face_normal #(
    parameter int COORD_FRAC_BITS  = 16,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic signed [31:0] a_w,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    input  logic signed [31:0] b_w,
    input  logic signed [31:0] c_x,
    input  logic signed [31:0] c_y,
    input  logic signed [31:0] c_z,
    input  logic signed [31:0] c_w,
    output logic               done,
    output logic signed [15:0] normal_x,
    output logic signed [15:0] normal_y,
    output logic signed [15:0] normal_z,
    output logic               degenerate
);

    localparam int CW   = tfn_pkg::COORD_W;
    localparam int QW   = CW + COORD_FRAC_BITS;
    localparam int VW   = QW + 1;
    localparam int EW   = QW + 2;
    localparam int EMW  = QW + 1;
    localparam int PW   = tfn_pkg::SCALE_W;
    localparam int SW   = PW + 1;
    localparam int PRW  = 2 * SW;
    localparam int CMW  = PRW - 1;
    localparam int SQW  = 2 * PW;
    localparam int SIW  = SQW + 2;
    localparam int LW   = SIW / 2;
    localparam int NW2  = PW + NORMAL_FRAC_BITS + 1;
    localparam int OW   = tfn_pkg::NORM_W;
    localparam int QCW  = OW + 1;
    localparam int SQSW = 3 * PW + 4;
    localparam int LAT  = QW + LW + NW2 + 15;
    localparam int ONE_N  = 1 << NORMAL_FRAC_BITS;
    localparam int OUT_HI = (ONE_N < tfn_pkg::SAT_POS) ? ONE_N : tfn_pkg::SAT_POS;
    localparam int OUT_LO = (ONE_N < tfn_pkg::SAT_MAG) ? ONE_N : tfn_pkg::SAT_MAG;

    logic              accept;
    logic [CW-1:0]     in_pt [12];

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    assign in_pt[0]  = a_x;
    assign in_pt[1]  = a_y;
    assign in_pt[2]  = a_z;
    assign in_pt[3]  = a_w;
    assign in_pt[4]  = b_x;
    assign in_pt[5]  = b_y;
    assign in_pt[6]  = b_z;
    assign in_pt[7]  = b_w;
    assign in_pt[8]  = c_x;
    assign in_pt[9]  = c_y;
    assign in_pt[10] = c_z;
    assign in_pt[11] = c_w;

    // Front: magnitudes and signs for the perspective divide.
    logic              v1_reg;
    logic [QW-1:0]     num1_reg [9];
    logic [CW-1:0]     den1_reg [9];
    logic              neg1_reg [9];
    logic              zw1_reg;

    // Perspective divide lanes.
    logic              v2_in;
    logic              zw2_in;
    logic [QW-1:0]     q2_in   [9];
    logic              neg2_in [9];

    logic              v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    logic              v9_reg, v10_reg, v11_reg, v12_reg, v13_reg, v14_reg, v15_reg;
    logic              dg2_reg, dg3_reg, dg4_reg, dg5_reg, dg6_reg, dg7_reg, dg8_reg;
    logic              dg9_reg, dg10_reg, dg11_reg, dg12_reg, dg13_reg, dg14_reg;

    logic signed [VW-1:0]  vx_reg   [9];
    logic signed [EW-1:0]  e_reg    [6];
    logic [EMW-1:0]        emag_reg [6];
    logic                  eneg_reg [6];
    logic [EMW-1:0]        eor_reg;
    logic [EMW-1:0]        emag5_reg [6];
    logic                  eneg5_reg [6];
    tfn_pkg::shift_t       es_reg;
    logic signed [SW-1:0]  ep_reg   [6];
    logic signed [PRW-1:0] prod_reg [6];
    logic signed [PRW-1:0] cr_reg   [3];
    logic [CMW-1:0]        cm_reg   [3];
    logic                  cn9_reg  [3];
    logic [CMW-1:0]        cor_reg;
    logic [CMW-1:0]        cm10_reg [3];
    logic                  cn10_reg [3];
    tfn_pkg::shift_t       ct_reg;
    logic [PW-1:0]         m11_reg  [3];
    logic                  cn11_reg [3];
    logic [SQW-1:0]        sq_reg   [3];
    logic [PW-1:0]         m12_reg  [3];
    logic                  cn12_reg [3];
    logic [SIW-1:0]        sum_reg;
    logic [PW-1:0]         m13_reg  [3];
    logic                  cn13_reg [3];

    // Root and normalise.
    logic                  sq_valid;
    logic [LW-1:0]         sq_root;
    logic [SQSW-1:0]       sq_side;
    logic [NW2-1:0]        num14_reg [3];
    logic [LW-1:0]         len14_reg;
    logic                  cn14_reg  [3];
    logic                  v15_in;
    logic                  dg15_in;
    logic [NW2-1:0]        q15_in   [3];
    logic                  neg15_in [3];

    logic [OW-1:0]         nout_reg [3];
    logic                  deg_reg;

    // Combinational helpers per stage.
    logic [QW-1:0]         num1_next [9];
    logic [CW-1:0]         den1_next [9];
    logic                  neg1_next [9];
    logic signed [VW-1:0]  vx_next   [9];
    logic [EW-1:0]         eabs      [6];
    logic [EMW-1:0]        eor_next;
    logic [EMW-1:0]        esh       [6];
    logic signed [SW-1:0]  ep_next   [6];
    logic [PRW-1:0]        cabs      [3];
    logic [CMW-1:0]        cor_next;
    logic                  cross_zero;
    logic [CMW-1:0]        csh       [3];
    logic [LW-1:0]         len_fix;
    logic [QCW-1:0]        qc        [3];
    logic [QCW-1:0]        qneg      [3];
    logic [OW-1:0]         nout_next [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                num1_next[k*3+i] = {tfn_pkg::abs_coord(in_pt[k*4+i]),
                                    {COORD_FRAC_BITS{1'b0}}};
                den1_next[k*3+i] = tfn_pkg::abs_coord(in_pt[k*4+3]);
                neg1_next[k*3+i] = in_pt[k*4+i][CW-1] ^ in_pt[k*4+3][CW-1];
            end
        end
    end

    for (genvar l = 0; l < 9; l++)
    begin : g_persp
        if (l == 0)
        begin : g_lead
            logic [1:0] side_out;
            tfn_div #(.NUM_W(QW), .DEN_W(CW), .SIDE_W(2)) u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (v1_reg),
                .in_num    (num1_reg[l]),
                .in_den    (den1_reg[l]),
                .in_side   ({neg1_reg[l], zw1_reg}),
                .out_valid (v2_in),
                .out_quot  (q2_in[l]),
                .out_side  (side_out)
            );
            assign neg2_in[l] = side_out[1];
            assign zw2_in     = side_out[0];
        end
        else
        begin : g_rest
            tfn_div #(.NUM_W(QW), .DEN_W(CW), .SIDE_W(1)) u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (v1_reg),
                .in_num    (num1_reg[l]),
                .in_den    (den1_reg[l]),
                .in_side   (neg1_reg[l]),
                .out_valid (),
                .out_quot  (q2_in[l]),
                .out_side  (neg2_in[l])
            );
        end
    end

    always_comb
    begin
        for (int l = 0; l < 9; l++)
        begin
            vx_next[l] = neg2_in[l] ? -$signed({1'b0, q2_in[l]}) : $signed({1'b0, q2_in[l]});
        end
        eor_next = '0;
        for (int i = 0; i < 6; i++)
        begin
            eabs[i]  = e_reg[i][EW-1] ? (~e_reg[i] + 1'b1) : e_reg[i];
            eor_next = eor_next | eabs[i][EMW-1:0];
        end
        for (int i = 0; i < 6; i++)
        begin
            esh[i]     = emag5_reg[i] >> es_reg;
            ep_next[i] = eneg5_reg[i] ? -$signed({1'b0, esh[i][PW-1:0]})
                                      : $signed({1'b0, esh[i][PW-1:0]});
        end
        cor_next   = '0;
        cross_zero = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            cabs[i]    = cr_reg[i][PRW-1] ? (~cr_reg[i] + 1'b1) : cr_reg[i];
            cor_next   = cor_next | cabs[i][CMW-1:0];
            cross_zero = cross_zero & (cr_reg[i] == '0);
        end
        for (int i = 0; i < 3; i++)
        begin
            csh[i] = cm10_reg[i] >> ct_reg;
        end
        len_fix = (sq_root == '0) ? LW'(1) : sq_root;
        for (int i = 0; i < 3; i++)
        begin
            qc[i]   = (q15_in[i] > NW2'(tfn_pkg::SAT_MAG)) ? QCW'(tfn_pkg::SAT_MAG)
                                                           : q15_in[i][QCW-1:0];
            qneg[i] = ~qc[i] + 1'b1;
            if (dg15_in)
            begin
                nout_next[i] = '0;
            end
            else if (neg15_in[i])
            begin
                nout_next[i] = qneg[i][OW-1:0];
            end
            else if (qc[i] > QCW'(tfn_pkg::SAT_POS))
            begin
                nout_next[i] = OW'(tfn_pkg::SAT_POS);
            end
            else
            begin
                nout_next[i] = qc[i][OW-1:0];
            end
        end
    end

    tfn_sqrt #(.IN_W(SIW), .SIDE_W(SQSW)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v13_reg),
        .in_rad    (sum_reg),
        .in_side   ({m13_reg[0], m13_reg[1], m13_reg[2],
                     cn13_reg[0], cn13_reg[1], cn13_reg[2], dg13_reg}),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    for (genvar l = 0; l < 3; l++)
    begin : g_norm
        if (l == 0)
        begin : g_lead
            logic [1:0] side_out;
            tfn_div #(.NUM_W(NW2), .DEN_W(LW), .SIDE_W(2)) u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (v14_reg),
                .in_num    (num14_reg[l]),
                .in_den    (len14_reg),
                .in_side   ({cn14_reg[l], dg14_reg}),
                .out_valid (v15_in),
                .out_quot  (q15_in[l]),
                .out_side  (side_out)
            );
            assign neg15_in[l] = side_out[1];
            assign dg15_in     = side_out[0];
        end
        else
        begin : g_rest
            tfn_div #(.NUM_W(NW2), .DEN_W(LW), .SIDE_W(1)) u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (v14_reg),
                .in_num    (num14_reg[l]),
                .in_den    (len14_reg),
                .in_side   (cn14_reg[l]),
                .out_valid (),
                .out_quot  (q15_in[l]),
                .out_side  (neg15_in[l])
            );
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
            v12_reg <= 1'b0;
            v13_reg <= 1'b0;
            v14_reg <= 1'b0;
            v15_reg <= 1'b0;
        end
        else
        begin
            v1_reg  <= accept;
            v2_reg  <= v2_in;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            v5_reg  <= v4_reg;
            v6_reg  <= v5_reg;
            v7_reg  <= v6_reg;
            v8_reg  <= v7_reg;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
            v11_reg <= v10_reg;
            v12_reg <= v11_reg;
            v13_reg <= v12_reg;
            v14_reg <= sq_valid;
            v15_reg <= v15_in;
        end
    end

    always_ff @(posedge clk)
    begin
        // Perspective divide operands, and the signed quotients.
        for (int l = 0; l < 9; l++)
        begin
            num1_reg[l] <= num1_next[l];
            den1_reg[l] <= den1_next[l];
            neg1_reg[l] <= neg1_next[l];
            vx_reg[l]   <= vx_next[l];
        end
        zw1_reg <= (a_w == '0) | (b_w == '0) | (c_w == '0);
        dg2_reg <= zw2_in;

        // Edges from the first vertex.
        for (int i = 0; i < 3; i++)
        begin
            e_reg[i]   <= $signed({vx_reg[3+i][VW-1], vx_reg[3+i]})
                        - $signed({vx_reg[i][VW-1], vx_reg[i]});
            e_reg[3+i] <= $signed({vx_reg[6+i][VW-1], vx_reg[6+i]})
                        - $signed({vx_reg[i][VW-1], vx_reg[i]});
        end
        dg3_reg <= dg2_reg;

        // Edge prescale: magnitudes, shift search, truncating shift.
        for (int i = 0; i < 6; i++)
        begin
            emag_reg[i]  <= eabs[i][EMW-1:0];
            eneg_reg[i]  <= e_reg[i][EW-1];
            emag5_reg[i] <= emag_reg[i];
            eneg5_reg[i] <= eneg_reg[i];
            ep_reg[i]    <= ep_next[i];
        end
        eor_reg <= eor_next;
        es_reg  <= tfn_pkg::over_shift(tfn_pkg::BITS_W'(eor_reg));
        dg4_reg <= dg3_reg;
        dg5_reg <= dg4_reg;
        dg6_reg <= dg5_reg;

        // Cross product.
        prod_reg[0] <= ep_reg[1] * ep_reg[5];
        prod_reg[1] <= ep_reg[2] * ep_reg[4];
        prod_reg[2] <= ep_reg[2] * ep_reg[3];
        prod_reg[3] <= ep_reg[0] * ep_reg[5];
        prod_reg[4] <= ep_reg[0] * ep_reg[4];
        prod_reg[5] <= ep_reg[1] * ep_reg[3];
        dg7_reg     <= dg6_reg;
        for (int i = 0; i < 3; i++)
        begin
            cr_reg[i] <= prod_reg[2*i] - prod_reg[2*i+1];
        end
        dg8_reg <= dg7_reg;

        // Cross prescale and squared length.
        for (int i = 0; i < 3; i++)
        begin
            cm_reg[i]   <= cabs[i][CMW-1:0];
            cn9_reg[i]  <= cr_reg[i][PRW-1];
            cm10_reg[i] <= cm_reg[i];
            cn10_reg[i] <= cn9_reg[i];
            m11_reg[i]  <= csh[i][PW-1:0];
            cn11_reg[i] <= cn10_reg[i];
            sq_reg[i]   <= SQW'(m11_reg[i]) * SQW'(m11_reg[i]);
            m12_reg[i]  <= m11_reg[i];
            cn12_reg[i] <= cn11_reg[i];
            m13_reg[i]  <= m12_reg[i];
            cn13_reg[i] <= cn12_reg[i];
        end
        cor_reg  <= cor_next;
        dg9_reg  <= dg8_reg | cross_zero;
        ct_reg   <= tfn_pkg::over_shift(tfn_pkg::BITS_W'(cor_reg));
        dg10_reg <= dg9_reg;
        dg11_reg <= dg10_reg;
        dg12_reg <= dg11_reg;
        sum_reg  <= SIW'(sq_reg[0]) + SIW'(sq_reg[1]) + SIW'(sq_reg[2]);
        dg13_reg <= dg12_reg;

        // Rounded numerators for the normalise divide.
        len14_reg    <= len_fix;
        num14_reg[0] <= {1'b0, sq_side[SQSW-1 -: PW], {NORMAL_FRAC_BITS{1'b0}}}
                      + NW2'(len_fix[LW-1:1]);
        num14_reg[1] <= {1'b0, sq_side[SQSW-1-PW -: PW], {NORMAL_FRAC_BITS{1'b0}}}
                      + NW2'(len_fix[LW-1:1]);
        num14_reg[2] <= {1'b0, sq_side[SQSW-1-2*PW -: PW], {NORMAL_FRAC_BITS{1'b0}}}
                      + NW2'(len_fix[LW-1:1]);
        cn14_reg[0]  <= sq_side[3];
        cn14_reg[1]  <= sq_side[2];
        cn14_reg[2]  <= sq_side[1];
        dg14_reg     <= sq_side[0];

        // Clamp, sign (or zero for a degenerate item) and hold the result for its single strobe cycle.
        for (int i = 0; i < 3; i++)
        begin
            nout_reg[i] <= nout_next[i];
        end
        deg_reg <= dg15_in;
    end

    assign done       = v15_reg;
    assign normal_x   = nout_reg[0];
    assign normal_y   = nout_reg[1];
    assign normal_z   = nout_reg[2];
    assign degenerate = deg_reg;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LAT done)
        else $error("item did not emerge at the pipeline depth");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT))
        else $error("result without a matching item");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
        else $error("degenerate item with a non-zero normal");

    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !degenerate |-> normal_x != '0 || normal_y != '0 || normal_z != '0)
        else $error("valid normal came out as zero");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> normal_x <= OUT_HI && normal_x >= -OUT_LO && normal_y <= OUT_HI
              && normal_y >= -OUT_LO && normal_z <= OUT_HI && normal_z >= -OUT_LO)
        else $error("normal component beyond unit length");
`endif

endmodule
